// ----- hdl/art_pkg.sv -----
`default_nettype none
package art_pkg;
	localparam int SEQ_W = 16;
	localparam int ADDR_W = 8;
	localparam int TIME_W = 32;
	localparam int RTRY_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_SENT = 2'd1;
	localparam logic [1:0] KIND_FAIL = 2'd2;
	localparam logic [1:0] KIND_RECV = 2'd3;

	localparam logic [1:0] PT_DATA = 2'd0;
	localparam logic [1:0] PT_ACK = 2'd1;

	localparam logic [2:0] EV_RETRY = 3'd0;
	localparam logic [2:0] EV_EXHAUST = 3'd1;
	localparam logic [2:0] EV_DROP = 3'd2;
	localparam logic [2:0] EV_NOSLOT = 3'd3;
	localparam logic [2:0] EV_ACK = 3'd4;
	localparam logic [2:0] EV_DONE = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAXRTRY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NODEID = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] packet_type;
		logic [15:0] seq_num;
		logic [7:0] dest_addr;
		logic [7:0] src_addr;
		logic [15:0] acked_seq;
		logic [31:0] now_ms;
		logic [3:0] queue_space;
	} in_word_t;

	typedef struct packed {
		logic [2:0] event_code;
		logic [2:0] slot_index;
		logic [15:0] event_seq;
		logic [7:0] event_dest;
		logic [3:0] retry_count;
		logic [3:0] pending_total;
		logic last;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input word
		logic clr_scan;  // reset scan index
		logic step;      // examine current slot, advance
		logic take;      // sent/fail: resolve slot (match or free)
		logic ack;       // receive: resolve ack
		logic emit_done; // build done word
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_end;  // index at last slot
		logic hit;       // word built by last action
	} dp_sts_t;
endpackage
`default_nettype wire

// ----- hdl/art_if.sv -----
`default_nettype none
interface art_if #(parameter int W = 8);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/art_dp.sv -----
`default_nettype none
module art_dp #(
	parameter int SLOTS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [art_pkg::CFG_IDX_W-1:0] cfg_idx,
	input wire logic [art_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire art_pkg::in_word_t in_word,
	input wire art_pkg::dp_cmd_t cmd,
	output art_pkg::dp_sts_t sts,
	output art_pkg::out_word_t res
);
	import art_pkg::*;
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	logic [31:0] timeout_q;
	logic [3:0] maxr_q;
	logic [7:0] node_q;
	in_word_t w_q;
	logic [3:0] space_q;
	logic [IW-1:0] idx_q;
	logic [SLOTS-1:0] act_q, mark_q;
	logic [15:0] seq_q [SLOTS];
	logic [7:0] hop_q [SLOTS];
	logic [3:0] rtr_q [SLOTS];
	logic [31:0] tim_q [SLOTS];
	logic hit_q;
	out_word_t res_q;

	// slot lookup: match by sequence, else lowest free
	logic [15:0] key;
	logic m_found, f_found;
	logic [IW-1:0] m_idx, f_idx;
	always_comb begin
		key = cmd.ack ? w_q.acked_seq : w_q.seq_num;
		m_found = 1'b0;
		f_found = 1'b0;
		m_idx = '0;
		f_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (act_q[i] && seq_q[i] == key) begin
				m_found = 1'b1;
				m_idx = IW'(i);
			end
			if (!act_q[i]) begin
				f_found = 1'b1;
				f_idx = IW'(i);
			end
		end
	end

	// active count
	logic [CW-1:0] cnt;
	always_comb begin
		cnt = '0;
		for (int i = 0; i < SLOTS; i++)
			cnt = cnt + CW'(act_q[i]);
	end

	// current tick slot
	logic [31:0] age;
	logic due;
	assign age = w_q.now_ms - tim_q[idx_q];
	assign due = act_q[idx_q] && !mark_q[idx_q] && age >= timeout_q;

	assign sts.scan_end = (idx_q == IW'(SLOTS - 1));
	assign sts.hit = hit_q;
	assign res = res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 32'd1000;
			maxr_q <= 4'd3;
			node_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_MAXRTRY: maxr_q <= cfg_data[3:0];
				REG_NODEID: node_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// slot table and event build
	always_ff @(posedge clk or negedge arst_n) begin
		logic [IW-1:0] s;
		logic [3:0] r;
		if (!arst_n) begin
			act_q <= '0;
			mark_q <= '0;
			idx_q <= '0;
			hit_q <= 1'b0;
		end else begin
			hit_q <= 1'b0;
			if (cmd.load) begin
				w_q <= in_word;
				space_q <= in_word.queue_space;
			end
			if (cmd.clr_scan) idx_q <= '0;
			if (cmd.step) begin
				if (!sts.scan_end) idx_q <= idx_q + 1'b1;
				if (due) begin
					hit_q <= 1'b1;
					r = rtr_q[idx_q];
					res_q <= '{default: '0};
					res_q.slot_index <= 3'(idx_q);
					res_q.event_seq <= seq_q[idx_q];
					res_q.event_dest <= hop_q[idx_q];
					if (r >= maxr_q) begin
						res_q.event_code <= EV_EXHAUST;
						res_q.retry_count <= r;
						act_q[idx_q] <= 1'b0;
					end else if (space_q == 4'd0) begin
						res_q.event_code <= EV_DROP;
						res_q.retry_count <= r;
						act_q[idx_q] <= 1'b0;
					end else begin
						space_q <= space_q - 4'd1;
						rtr_q[idx_q] <= r + 4'd1;
						mark_q[idx_q] <= 1'b1;
						res_q.event_code <= EV_RETRY;
						res_q.retry_count <= r + 4'd1;
					end
				end
			end
			if (cmd.take && w_q.packet_type == PT_DATA) begin
				s = m_found ? m_idx : f_idx;
				r = m_found ? rtr_q[m_idx] : 4'd0;
				if (m_found || f_found) begin
					if (!m_found) begin
						seq_q[s] <= w_q.seq_num;
						hop_q[s] <= w_q.dest_addr;
						act_q[s] <= 1'b1;
					end
					rtr_q[s] <= r;
				end
				res_q <= '{default: '0};
				if (w_q.kind == KIND_SENT) begin
					if (m_found || f_found) begin
						tim_q[s] <= w_q.now_ms;
						mark_q[s] <= 1'b0;
					end
				end else if (!(m_found || f_found)) begin
					hit_q <= 1'b1;
					res_q.event_code <= EV_NOSLOT;
					res_q.event_seq <= w_q.seq_num;
					res_q.event_dest <= w_q.dest_addr;
				end else begin
					hit_q <= 1'b1;
					res_q.slot_index <= 3'(s);
					res_q.event_seq <= w_q.seq_num;
					res_q.event_dest <= m_found ? hop_q[s] : w_q.dest_addr;
					if (r >= maxr_q) begin
						res_q.event_code <= EV_EXHAUST;
						res_q.retry_count <= r;
						act_q[s] <= 1'b0;
					end else if (space_q == 4'd0) begin
						res_q.event_code <= EV_DROP;
						res_q.retry_count <= r;
						act_q[s] <= 1'b0;
					end else begin
						rtr_q[s] <= r + 4'd1;
						mark_q[s] <= 1'b1;
						res_q.event_code <= EV_RETRY;
						res_q.retry_count <= r + 4'd1;
					end
				end
			end
			if (cmd.ack) begin
				res_q <= '{default: '0};
				if (w_q.packet_type == PT_ACK && w_q.dest_addr == node_q && m_found
					&& hop_q[m_idx] == w_q.src_addr) begin
					hit_q <= 1'b1;
					act_q[m_idx] <= 1'b0;
					res_q.event_code <= EV_ACK;
					res_q.slot_index <= 3'(m_idx);
					res_q.event_seq <= seq_q[m_idx];
					res_q.event_dest <= hop_q[m_idx];
					res_q.retry_count <= rtr_q[m_idx];
				end
			end
			if (cmd.emit_done) begin
				res_q <= '{default: '0};
				res_q.event_code <= EV_DONE;
				res_q.pending_total <= (cnt > CW'(15)) ? 4'd15 : 4'(cnt);
				res_q.last <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/art_ctrl.sv -----
`default_nettype none
module art_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic [1:0] in_kind,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output art_pkg::dp_cmd_t cmd,
	input wire art_pkg::dp_sts_t sts
);
	import art_pkg::*;
	typedef enum logic [2:0] {
		ST_IDLE, ST_DISP, ST_SCAN, ST_CHK, ST_SHOW, ST_DONE, ST_LAST
	} state_t;
	state_t st_q;
	logic [1:0] kind_q;
	logic end_q;

	assign in_ready = (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_SHOW) || (st_q == ST_LAST);

	always_comb begin
		cmd = '0;
		case (st_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				cmd.clr_scan = in_valid;
			end
			ST_DISP: begin
				cmd.step = (kind_q == KIND_TICK);
				cmd.take = (kind_q == KIND_SENT) || (kind_q == KIND_FAIL);
				cmd.ack = (kind_q == KIND_RECV);
			end
			ST_SCAN: cmd.step = 1'b1;
			ST_DONE: cmd.emit_done = 1'b1;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			kind_q <= KIND_TICK;
			end_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: if (in_valid) begin
					kind_q <= in_kind;
					st_q <= ST_DISP;
				end
				ST_DISP, ST_SCAN: begin
					end_q <= (kind_q != KIND_TICK) || sts.scan_end;
					st_q <= ST_CHK;
				end
				ST_CHK: st_q <= sts.hit ? ST_SHOW : (end_q ? ST_DONE : ST_SCAN);
				ST_SHOW: if (out_ready) st_q <= end_q ? ST_DONE : ST_SCAN;
				ST_DONE: st_q <= ST_LAST;
				ST_LAST: if (out_ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept during output");
	a_last_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_LAST |-> $past(st_q) == ST_DONE || $past(st_q) == ST_LAST)
		else $error("done word without build");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("output dropped");
endmodule
`default_nettype wire

// ----- hdl/ack_retransmit_tracker.sv -----
// Non-tick items pass dispatch and check, then show any event word before the done word.
// Tick: each slot passes an examine and a check state, plus a show state per word shown.
// One item in flight; next accepted after the closing done word is taken.
// The sequential slot scan of the shared check unit sets the tick rate.
// arst_n clears the sequencer, the active and retry-mark flags, and reloads register defaults.
`default_nettype none
module ack_retransmit_tracker #(
	parameter int SLOTS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	art_if.sink in_ch,
	art_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [art_pkg::CFG_IDX_W-1:0] cfg_idx,
	input wire logic [art_pkg::CFG_DATA_W-1:0] cfg_data
);
	import art_pkg::*;
	dp_cmd_t cmd;
	dp_sts_t sts;
	in_word_t iw;
	out_word_t ow;

	assign iw = in_ch.data;
	assign out_ch.data = ow;

	art_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_kind(iw.kind), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd, .sts
	);

	art_dp #(.SLOTS(SLOTS)) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.in_word(iw), .cmd, .sts, .res(ow)
	);
endmodule
`default_nettype wire

// ----- tb/sv/ack_retransmit_tracker_tb.sv -----
module ack_retransmit_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import art_pkg::*;

	localparam int NSLOT = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	art_if #(.W($bits(in_word_t))) in_ch ();
	art_if #(.W($bits(out_word_t))) out_ch ();

	ack_retransmit_tracker #(.SLOTS(NSLOT)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the slot table
	logic [31:0] m_timeout;
	logic [3:0] m_max_rtry;
	logic [7:0] m_node;
	logic m_active [NSLOT];
	logic m_marked [NSLOT];
	logic [15:0] m_seq [NSLOT];
	logic [7:0] m_hop [NSLOT];
	logic [3:0] m_rtry [NSLOT];
	logic [31:0] m_stamp [NSLOT];

	out_word_t expected_words[$];
	int errors = 0;
	bit rx_hold = 1'b0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	function automatic out_word_t mk_word(logic [2:0] code, int s, logic [15:0] seq,
			logic [7:0] dst, logic [3:0] rc, logic [3:0] tot, logic lst);
		out_word_t w;
		w.event_code = code;
		w.slot_index = s[2:0];
		w.event_seq = seq;
		w.event_dest = dst;
		w.retry_count = rc;
		w.pending_total = tot;
		w.last = lst;
		return w;
	endfunction

	function automatic int lookup_seq(logic [15:0] seq);
		for (int i = 0; i < NSLOT; i++)
			if (m_active[i] && m_seq[i] == seq) return i;
		return -1;
	endfunction

	function automatic int claim_slot(logic [15:0] seq, logic [7:0] dst);
		int s;
		s = lookup_seq(seq);
		if (s < 0) begin
			for (int i = 0; i < NSLOT; i++)
				if (!m_active[i]) begin
					s = i;
					break;
				end
			if (s < 0) return -1;
			m_seq[s] = seq;
			m_hop[s] = dst;
			m_rtry[s] = 4'd0;
			m_active[s] = 1'b1;
		end
		return s;
	endfunction

	function automatic void retry_slot(int s, ref logic [3:0] space);
		logic [2:0] code;
		if (m_rtry[s] >= m_max_rtry) begin
			code = EV_EXHAUST;
			m_active[s] = 1'b0;
		end else if (space == 0) begin
			code = EV_DROP;
			m_active[s] = 1'b0;
		end else begin
			space--;
			m_rtry[s]++;
			m_marked[s] = 1'b1;
			code = EV_RETRY;
		end
		expected_words.push_back(mk_word(code, s, m_seq[s], m_hop[s], m_rtry[s], 0, 0));
	endfunction

	// compute the words one input word produces
	function automatic void predict_tracker(in_word_t w);
		logic [3:0] space;
		int s;
		int tot;
		space = w.queue_space;
		tot = 0;
		case (w.kind)
			KIND_TICK: begin
				for (int i = 0; i < NSLOT; i++)
					if (m_active[i] && !m_marked[i] && (w.now_ms - m_stamp[i]) >= m_timeout)
						retry_slot(i, space);
			end
			KIND_SENT: begin
				if (w.packet_type == PT_DATA) begin
					s = claim_slot(w.seq_num, w.dest_addr);
					if (s >= 0) begin
						m_stamp[s] = w.now_ms;
						m_marked[s] = 1'b0;
					end
				end
			end
			KIND_FAIL: begin
				if (w.packet_type == PT_DATA) begin
					s = claim_slot(w.seq_num, w.dest_addr);
					if (s < 0)
						expected_words.push_back(mk_word(EV_NOSLOT, 0, w.seq_num,
							w.dest_addr, 0, 0, 0));
					else
						retry_slot(s, space);
				end
			end
			default: begin
				if (w.packet_type == PT_ACK && w.dest_addr == m_node) begin
					s = lookup_seq(w.acked_seq);
					if (s >= 0 && m_hop[s] == w.src_addr) begin
						m_active[s] = 1'b0;
						expected_words.push_back(mk_word(EV_ACK, s, m_seq[s], m_hop[s],
							m_rtry[s], 0, 0));
					end
				end
			end
		endcase
		for (int i = 0; i < NSLOT; i++)
			if (m_active[i]) tot++;
		expected_words.push_back(mk_word(EV_DONE, 0, 0, 0, 0, tot[3:0], 1'b1));
	endfunction

	// valid stays high across back-to-back words unless a random gap drops it; drain_wait also drops it
	task automatic send_word(in_word_t w);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_tracker(w);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TIMEOUT: m_timeout = val;
			REG_MAXRTRY: m_max_rtry = val[3:0];
			default: m_node = val[7:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain_wait();
		in_ch.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic in_word_t blank_word();
		in_word_t w;
		w = '0;
		return w;
	endfunction

	function automatic in_word_t ev(logic [1:0] k, logic [1:0] pt, logic [15:0] seq,
			logic [7:0] dst, logic [31:0] now_v, logic [3:0] space);
		in_word_t w;
		w = blank_word();
		w.kind = k;
		w.packet_type = pt;
		w.seq_num = seq;
		w.dest_addr = dst;
		w.now_ms = now_v;
		w.queue_space = space;
		return w;
	endfunction

	function automatic in_word_t ack_word(logic [15:0] seq, logic [7:0] src, logic [7:0] dst);
		in_word_t w;
		w = blank_word();
		w.kind = KIND_RECV;
		w.packet_type = PT_ACK;
		w.acked_seq = seq;
		w.src_addr = src;
		w.dest_addr = dst;
		return w;
	endfunction

	// receiver: random stalls, compare against oldest expectation
	always @(posedge clk) begin
		out_word_t got;
		out_word_t exp_w;
		if (out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_words.size() == 0) begin
				$display("%0t unexpected word %h", $time, got);
				errors++;
			end else begin
				exp_w = expected_words.pop_front();
				if (got !== exp_w) begin
					$display("%0t mismatch expected %h actual %h", $time, exp_w, got);
					errors++;
				end
			end
		end
	end

	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			if (rx_hold) begin
				out_ch.ready <= 1'b0;
				@(posedge clk);
			end else begin
				wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
				if (wait_n > 0) begin
					out_ch.ready <= 1'b0;
					repeat (wait_n) @(posedge clk);
				end
				out_ch.ready <= 1'b1;
				@(posedge clk);
				while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
			end
		end
	end

	// extremes, every kind and each corner of the slot table
	task automatic test_directed();
		send_word(ev(KIND_TICK, PT_DATA, 0, 0, 32'h0, 0));
		for (int i = 0; i < NSLOT; i++)
			send_word(ev(KIND_SENT, PT_DATA, 16'(16'hFFF0 + i), 8'(8'hA0 + i),
				32'hFFFF_FF00, 4'hF));
		// table full
		send_word(ev(KIND_FAIL, PT_DATA, 16'h1234, 8'hFF, 0, 1));
		send_word(ev(KIND_SENT, PT_DATA, 16'h1234, 8'hFF, 0, 1));
		send_word(ev(KIND_SENT, 2'd2, 16'h1, 1, 0, 0));
		send_word(ev(KIND_FAIL, PT_ACK, 16'h1, 1, 0, 0));
		// wrapped age, space runs out mid scan
		send_word(ev(KIND_TICK, PT_DATA, 0, 0, 32'h0000_02F0, 4'd3));
		send_word(ev(KIND_TICK, PT_DATA, 0, 0, 32'h0000_0400, 4'd3));
		send_word(ack_word(16'hFFF0, 8'hA0, 8'd1));
		send_word(ack_word(16'hFFF1, 8'hA0, 8'd1));
		send_word(ack_word(16'hFFF1, 8'hA1, 8'd2));
		send_word(ack_word(16'hFFF1, 8'hA1, 8'd1));
		send_word(ev(KIND_RECV, PT_DATA, 16'hFFF2, 8'd1, 0, 0));
		send_word(ev(KIND_FAIL, PT_DATA, 16'hFFF2, 8'hA2, 0, 4'hF));
		send_word(ev(KIND_FAIL, PT_DATA, 16'hFFF2, 8'hA2, 0, 4'hF));
		send_word(ev(KIND_FAIL, PT_DATA, 16'hFFF2, 8'hA2, 0, 4'hF));
		send_word(ev(KIND_FAIL, PT_DATA, 16'hFFF2, 8'hA2, 0, 0));
		send_word(ev(KIND_FAIL, PT_DATA, 16'h0000, 8'h00, 0, 0));
		drain_wait();
	endtask

	// random traffic on a small set of sequences so slots get reused
	task automatic test_random(int count, logic [15:0] seq_base);
		in_word_t w;
		logic [31:0] clock_ms;
		logic [95:0] raw;
		int pick;
		clock_ms = $urandom;
		for (int n = 0; n < count; n++) begin
			clock_ms += $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 1500);
			pick = $urandom_range(0, 99);
			w = blank_word();
			w.now_ms = clock_ms;
			w.queue_space = 4'($urandom_range(0, 15));
			if (pick < 35) begin
				w.kind = KIND_SENT;
				w.packet_type = ($urandom_range(0, 9) == 0) ? 2'($urandom) : PT_DATA;
				w.seq_num = 16'(seq_base + $urandom_range(0, 11));
				w.dest_addr = 8'($urandom_range(0, 3));
			end else if (pick < 50) begin
				w.kind = KIND_FAIL;
				w.packet_type = ($urandom_range(0, 9) == 0) ? 2'($urandom) : PT_DATA;
				w.seq_num = 16'(seq_base + $urandom_range(0, 11));
				w.dest_addr = 8'($urandom_range(0, 3));
			end else if (pick < 75) begin
				w.kind = KIND_TICK;
			end else if (pick < 95) begin
				w.kind = KIND_RECV;
				w.packet_type = ($urandom_range(0, 9) == 0) ? 2'($urandom) : PT_ACK;
				w.dest_addr = ($urandom_range(0, 4) == 0) ? 8'($urandom) : m_node;
				w.acked_seq = 16'(seq_base + $urandom_range(0, 11));
				w.src_addr = 8'($urandom_range(0, 3));
			end else begin
				raw = {$urandom, $urandom, $urandom};
				w = raw[$bits(in_word_t)-1:0];
			end
			send_word(w);
		end
		drain_wait();
	endtask

	// receiver stalls long while the sender keeps offering words
	task automatic test_backpressure();
		fork
			begin
				rx_hold = 1'b1;
				repeat (300) @(posedge clk);
				rx_hold = 1'b0;
			end
			test_random(20, 16'h8000);
		join
	endtask

	initial begin
		m_timeout = 1000;
		m_max_rtry = 3;
		m_node = 1;
		for (int i = 0; i < NSLOT; i++) begin
			m_active[i] = 0;
			m_marked[i] = 0;
			m_stamp[i] = 0;
			m_seq[i] = 0;
			m_hop[i] = 0;
			m_rtry[i] = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(80, 16'h0000);
		write_reg(REG_TIMEOUT, 32'd0);
		write_reg(REG_MAXRTRY, 32'd0);
		write_reg(REG_NODEID, 32'd255);
		test_random(50, 16'hFFF0);
		write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
		write_reg(REG_MAXRTRY, 32'd15);
		write_reg(REG_NODEID, 32'd0);
		test_random(40, 16'h5555);
		write_reg(REG_TIMEOUT, 32'd700);
		write_reg(REG_MAXRTRY, 32'd5);
		write_reg(REG_NODEID, 32'hAA);
		test_backpressure();
		test_random(100, 16'hAAAA);
		drain_wait();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

// ----- filelist.f -----
hdl/art_pkg.sv
hdl/art_if.sv
hdl/art_dp.sv
hdl/art_ctrl.sv
hdl/ack_retransmit_tracker.sv
tb/sv/ack_retransmit_tracker_tb.sv
